[src/cpsc_pkg.sv]
package cpsc_pkg;

    // configuration port widths
    localparam int CfgIndexWidth = 4;
    localparam int CfgDataWidth  = 8;

    // register indexes
    localparam logic [CfgIndexWidth-1:0] CFG_MIN_TEMP          = 4'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_MAX_TEMP          = 4'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_TEMP_WINDOW_TICKS = 4'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_SAVE_DELAY_TICKS  = 4'd3;

    // register reset values
    localparam logic [5:0] MinTempReset         = 6'd17;
    localparam logic [5:0] MaxTempReset         = 6'd30;
    localparam logic [7:0] TempWindowTicksReset = 8'd22;
    localparam logic [7:0] SaveDelayTicksReset  = 8'd255;

    // item kinds
    localparam logic ITEM_TICK = 1'b0;
    localparam logic ITEM_KEY  = 1'b1;

    // key codes
    localparam logic [2:0] BTN_MODE  = 3'd0;
    localparam logic [2:0] BTN_FAN   = 3'd1;
    localparam logic [2:0] BTN_POWER = 3'd2;
    localparam logic [2:0] BTN_DOWN  = 3'd3;
    localparam logic [2:0] BTN_UP    = 3'd4;

    // state reset values and led pattern timing
    localparam logic [5:0] TempReset   = 6'd24;
    localparam logic [7:0] WindowReset = 8'd12;
    localparam logic [2:0] FlashReset  = 3'd1;
    localparam logic [2:0] SaveFlashes = 3'd7;
    localparam logic [1:0] FlashTicks  = 2'd2;
    localparam logic [2:0] GapTicks    = 3'd5;

    typedef struct packed {
        logic       mode;
        logic [2:0] key_code;
    } cpsc_in_t;

    typedef struct packed {
        logic       led;
        logic       power_on;
        logic [1:0] op_mode;
        logic [5:0] set_temp;
        logic [1:0] fan_speed;
        logic       save_request;
    } cpsc_out_t;

    typedef struct packed {
        logic [5:0] min_temp;
        logic [5:0] max_temp;
        logic [7:0] temp_window_ticks;
        logic [7:0] save_delay_ticks;
    } cpsc_cfg_t;

endpackage

[src/cpsc_cfg_regs.sv]
module cpsc_cfg_regs
    import cpsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [CfgIndexWidth-1:0] wr_index,
    input  logic [CfgDataWidth-1:0]  wr_data,
    output cpsc_cfg_t                cfg
);

    cpsc_cfg_t cfg_reg;
    cpsc_cfg_t cfg_next;

    // register write decode, unknown indexes dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_MIN_TEMP:          cfg_next.min_temp          = wr_data[5:0];
                CFG_MAX_TEMP:          cfg_next.max_temp          = wr_data[5:0];
                CFG_TEMP_WINDOW_TICKS: cfg_next.temp_window_ticks = wr_data;
                CFG_SAVE_DELAY_TICKS:  cfg_next.save_delay_ticks  = wr_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_temp          <= MinTempReset;
            cfg_reg.max_temp          <= MaxTempReset;
            cfg_reg.temp_window_ticks <= TempWindowTicksReset;
            cfg_reg.save_delay_ticks  <= SaveDelayTicksReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/cpsc_engine.sv]
module cpsc_engine
    import cpsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  cpsc_in_t  item,
    input  cpsc_cfg_t cfg,
    output cpsc_out_t result
);

    logic       key_paused_reg, key_paused_next;
    logic       power_reg, power_next;
    logic [1:0] op_mode_reg, op_mode_next;
    logic [5:0] temp_reg, temp_next;
    logic [1:0] fan_reg, fan_next;
    logic [7:0] window_reg, window_next;
    logic [7:0] save_count_reg, save_count_next;
    logic [2:0] flash_reg, flash_next;
    logic [1:0] led_on_reg, led_on_next;
    logic [2:0] led_off_reg, led_off_next;
    logic       led_reg, led_next;
    logic       save_request;

    // 0, 1, 2, 0, ...
    function automatic logic [1:0] cycle3(input logic [1:0] v);
        return (v >= 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

    // next state for the item in the input register
    always_comb
    begin
        key_paused_next = key_paused_reg;
        power_next      = power_reg;
        op_mode_next    = op_mode_reg;
        temp_next       = temp_reg;
        fan_next        = fan_reg;
        window_next     = window_reg;
        save_count_next = save_count_reg;
        flash_next      = flash_reg;
        led_on_next     = led_on_reg;
        led_off_next    = led_off_reg;
        led_next        = led_reg;
        save_request    = 1'b0;

        if (item.mode == ITEM_TICK)
        begin
            key_paused_next = 1'b0;
            if (window_reg != 8'd0)
                window_next = window_reg - 8'd1;
            if (save_count_reg != 8'd0)
                save_count_next = save_count_reg - 8'd1;
            // led flash pattern
            if (led_on_reg != 2'd0)
            begin
                led_next    = 1'b1;
                led_on_next = led_on_reg - 2'd1;
            end
            else if (led_off_reg != 3'd0)
            begin
                led_next     = 1'b0;
                led_off_next = led_off_reg - 3'd1;
            end
            else if (flash_reg != 3'd0)
            begin
                led_on_next  = FlashTicks;
                led_off_next = {1'b0, FlashTicks};
                flash_next   = flash_reg - 3'd1;
                if (flash_reg == 3'd1)
                    led_off_next = GapTicks;
            end
        end
        else if (!key_paused_reg)
        begin
            key_paused_next = 1'b1;
            unique case (item.key_code)
                BTN_MODE:
                begin
                    op_mode_next    = cycle3(op_mode_reg);
                    flash_next      = {1'b0, op_mode_next} + 3'd1;
                    save_count_next = cfg.save_delay_ticks;
                end
                BTN_FAN:
                begin
                    fan_next        = cycle3(fan_reg);
                    flash_next      = {1'b0, fan_next} + 3'd1;
                    save_count_next = cfg.save_delay_ticks;
                end
                BTN_POWER:
                begin
                    power_next      = !power_reg;
                    flash_next      = power_next ? 3'd2 : 3'd1;
                    save_count_next = cfg.save_delay_ticks;
                end
                BTN_DOWN:
                begin
                    if (window_reg != 8'd0 && temp_reg > cfg.min_temp)
                    begin
                        temp_next  = temp_reg - 6'd1;
                        flash_next = 3'd1;
                    end
                    window_next     = cfg.temp_window_ticks;
                    save_count_next = cfg.save_delay_ticks;
                end
                BTN_UP:
                begin
                    if (window_reg != 8'd0 && temp_reg < cfg.max_temp)
                    begin
                        temp_next  = temp_reg + 6'd1;
                        flash_next = 3'd1;
                    end
                    window_next     = cfg.temp_window_ticks;
                    save_count_next = cfg.save_delay_ticks;
                end
                default:
                begin
                    key_paused_next = 1'b1;
                end
            endcase
        end

        // save delay expiry
        if (save_count_next == 8'd1)
        begin
            save_count_next = 8'd0;
            flash_next      = SaveFlashes;
            save_request    = 1'b1;
        end
    end

    // settings state, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_paused_reg <= 1'b0;
            power_reg      <= 1'b0;
            op_mode_reg    <= 2'd0;
            temp_reg       <= TempReset;
            fan_reg        <= 2'd0;
            window_reg     <= WindowReset;
            save_count_reg <= 8'd0;
            flash_reg      <= FlashReset;
            led_on_reg     <= 2'd0;
            led_off_reg    <= 3'd0;
            led_reg        <= 1'b0;
        end
        else if (step)
        begin
            key_paused_reg <= key_paused_next;
            power_reg      <= power_next;
            op_mode_reg    <= op_mode_next;
            temp_reg       <= temp_next;
            fan_reg        <= fan_next;
            window_reg     <= window_next;
            save_count_reg <= save_count_next;
            flash_reg      <= flash_next;
            led_on_reg     <= led_on_next;
            led_off_reg    <= led_off_next;
            led_reg        <= led_next;
        end
    end

    // result fields from the updated state
    always_comb
    begin
        result.led          = led_next;
        result.power_on     = power_next;
        result.op_mode      = op_mode_next;
        result.set_temp     = temp_next;
        result.fan_speed    = fan_next;
        result.save_request = save_request;
    end

endmodule

[src/climate_panel_settings_controller_unit.sv]
// Climate panel settings controller.
//
// Input channel (in_valid / in_ready / in_data): one item per timer tick or
// decoded key press. Output channel (out_valid / out_ready / out_data): one
// result item per input item, in order, with led, power, mode, set
// temperature, fan speed and a one-item save request.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// index 0 min_temp, 1 max_temp, 2 temp_window_ticks, 3 save_delay_ticks;
// other indexes are dropped. cfg_ready is always high; write only while idle.
//
// An accepted item is first held in the input register, and its result is
// registered in the result register when the item advances. Throughput is
// one item per cycle while the receiver takes results, set by the single
// state update between the input register and the result register.
// Reset clears both stages and returns the settings and registers to their
// defaults. When the receiver stalls, the result holds and the input stage
// still takes one more item; after that in_ready drops until out_ready.
module climate_panel_settings_controller_unit
    import cpsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  cpsc_in_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output cpsc_out_t                out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data
);

    logic      in_valid_reg;
    cpsc_in_t  in_data_reg;
    logic      out_valid_reg;
    cpsc_out_t out_data_reg;
    logic      advance;
    cpsc_cfg_t cfg;
    cpsc_out_t result;

    // item moves from input register to result register
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    cpsc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    cpsc_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[src/cpsc_checker.sv]
module cpsc_checker
    import cpsc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input cpsc_out_t out_data
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // input side only backs up behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked without output stall");

    // mode and fan stay within three steps
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.op_mode != 2'd3 && out_data.fan_speed != 2'd3)
        else $error("mode or fan out of range");

    // an item accepted while no result is shown always yields a result after the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid)
        else $error("accepted item gave no result");

endmodule

bind climate_panel_settings_controller_unit cpsc_checker u_cpsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[verif/panel_checker.sv]
`timescale 1ns / 1ps

module panel_checker
    import cpsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  cpsc_in_t                 in_data,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  cpsc_out_t                out_data,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    output int unsigned              pending,
    output int unsigned              fails
);

    // predicted panel settings and the register copy
    cpsc_cfg_t  settings;
    logic       paused;
    logic       pwr;
    logic [1:0] opm;
    logic [5:0] temp;
    logic [1:0] fan;
    logic [7:0] window_cnt;
    logic [7:0] save_cnt;
    logic [2:0] flashes;
    logic [1:0] on_cnt;
    logic [2:0] off_cnt;
    logic       led_lvl;

    // panel results still owed by the block, oldest first
    cpsc_out_t  owed_panel_q[$];

    function automatic logic [1:0] wrap3(input logic [1:0] v);
        return (v >= 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

    task automatic clear_panel();
        settings   = '{MinTempReset, MaxTempReset, TempWindowTicksReset, SaveDelayTicksReset};
        paused     = 1'b0;
        pwr        = 1'b0;
        opm        = 2'd0;
        temp       = TempReset;
        fan        = 2'd0;
        window_cnt = WindowReset;
        save_cnt   = 8'd0;
        flashes    = FlashReset;
        on_cnt     = 2'd0;
        off_cnt    = 3'd0;
        led_lvl    = 1'b0;
    endtask

    // one tick or key press through the panel, giving its result item
    task automatic step_panel(input cpsc_in_t it, output cpsc_out_t res);
        logic saving;
        saving = 1'b0;
        if (it.mode == ITEM_KEY)
        begin
            if (!paused)
            begin
                paused = 1'b1;
                case (it.key_code)
                    BTN_MODE:
                    begin
                        opm      = wrap3(opm);
                        flashes  = {1'b0, opm} + 3'd1;
                        save_cnt = settings.save_delay_ticks;
                    end
                    BTN_FAN:
                    begin
                        fan      = wrap3(fan);
                        flashes  = {1'b0, fan} + 3'd1;
                        save_cnt = settings.save_delay_ticks;
                    end
                    BTN_POWER:
                    begin
                        pwr      = !pwr;
                        flashes  = pwr ? 3'd2 : 3'd1;
                        save_cnt = settings.save_delay_ticks;
                    end
                    BTN_DOWN:
                    begin
                        if (window_cnt != 8'd0 && temp > settings.min_temp)
                        begin
                            temp    = temp - 6'd1;
                            flashes = 3'd1;
                        end
                        window_cnt = settings.temp_window_ticks;
                        save_cnt   = settings.save_delay_ticks;
                    end
                    BTN_UP:
                    begin
                        if (window_cnt != 8'd0 && temp < settings.max_temp)
                        begin
                            temp    = temp + 6'd1;
                            flashes = 3'd1;
                        end
                        window_cnt = settings.temp_window_ticks;
                        save_cnt   = settings.save_delay_ticks;
                    end
                    default: ;
                endcase
            end
        end
        else
        begin
            paused = 1'b0;
            if (window_cnt != 8'd0) window_cnt = window_cnt - 8'd1;
            if (save_cnt != 8'd0) save_cnt = save_cnt - 8'd1;
            // led pattern: lit phase, dark phase, then next flash
            if (on_cnt != 2'd0)
            begin
                led_lvl = 1'b1;
                on_cnt  = on_cnt - 2'd1;
            end
            else if (off_cnt != 3'd0)
            begin
                led_lvl = 1'b0;
                off_cnt = off_cnt - 3'd1;
            end
            else if (flashes != 3'd0)
            begin
                on_cnt  = FlashTicks;
                off_cnt = {1'b0, FlashTicks};
                flashes = flashes - 3'd1;
                if (flashes == 3'd0) off_cnt = GapTicks;
            end
        end
        // save request once the delay runs out
        if (save_cnt == 8'd1)
        begin
            save_cnt = 8'd0;
            saving   = 1'b1;
            flashes  = SaveFlashes;
        end
        res = '{led: led_lvl, power_on: pwr, op_mode: opm, set_temp: temp,
                fan_speed: fan, save_request: saving};
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            fails++;
        end
    endtask

    // compare results, track register writes, predict accepted items
    always @(posedge clk or negedge rst_n)
    begin
        cpsc_out_t want;
        cpsc_out_t next_res;
        if (!rst_n)
        begin
            clear_panel();
            owed_panel_q.delete();
            fails = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (owed_panel_q.size() == 0)
                begin
                    $error("result item with nothing expected");
                    fails++;
                end
                else
                begin
                    want = owed_panel_q.pop_front();
                    check_field("led", want.led, out_data.led);
                    check_field("power_on", want.power_on, out_data.power_on);
                    check_field("op_mode", want.op_mode, out_data.op_mode);
                    check_field("set_temp", want.set_temp, out_data.set_temp);
                    check_field("fan_speed", want.fan_speed, out_data.fan_speed);
                    check_field("save_request", want.save_request, out_data.save_request);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MIN_TEMP:          settings.min_temp          = cfg_data[5:0];
                    CFG_MAX_TEMP:          settings.max_temp          = cfg_data[5:0];
                    CFG_TEMP_WINDOW_TICKS: settings.temp_window_ticks = cfg_data;
                    CFG_SAVE_DELAY_TICKS:  settings.save_delay_ticks  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                step_panel(in_data, next_res);
                owed_panel_q.push_back(next_res);
            end
        end
        pending = owed_panel_q.size();
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import cpsc_pkg::*;

    // key codes the block does not decode
    localparam logic [2:0] BTN_SPARE_A = 3'd5;
    localparam logic [2:0] BTN_SPARE_B = 3'd6;
    localparam logic [2:0] BTN_SPARE_C = 3'd7;
    // first register index past the last real register
    localparam logic [CfgIndexWidth-1:0] CFG_UNUSED_FIRST = CFG_SAVE_DELAY_TICKS + 4'd1;
    localparam int PhaseCount  = 7;
    localparam int PhaseItems  = 146;
    localparam int HoldCycles  = 60;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    cpsc_in_t                 in_data;
    logic                     out_valid;
    logic                     out_ready;
    cpsc_out_t                out_data;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_data;
    int unsigned              pending;
    int unsigned              fails;

    // shared between the sender and the receiver process
    logic quiet;
    int   holds_asked;

    climate_panel_settings_controller_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    panel_checker u_panel_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .fails     (fails)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // offer one item, hold it until taken, return at the next falling edge
    task automatic offer_item(input logic kind, input logic [2:0] code);
        in_data  <= '{mode: kind, key_code: code};
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic pause_input(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // register write, valid left high for a following write
    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // let every owed result come out before touching registers
    task automatic drain_panel();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic set_panel_regs(input logic [5:0] lo, input logic [5:0] hi,
                                  input logic [7:0] win, input logic [7:0] dly);
        write_reg(CFG_MIN_TEMP, {2'($urandom_range(0, 3)), lo});
        write_reg(CFG_MAX_TEMP, {2'($urandom_range(0, 3)), hi});
        write_reg(CFG_TEMP_WINDOW_TICKS, win);
        write_reg(CFG_SAVE_DELAY_TICKS, dly);
        write_reg(4'($urandom_range(CFG_UNUSED_FIRST, 15)), 8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [2:0] pick_key();
        if ($urandom_range(0, 15) < 13)
            return 3'($urandom_range(BTN_MODE, BTN_UP));
        return 3'($urandom_range(BTN_SPARE_A, BTN_SPARE_C));
    endfunction

    // receiver: random stall bursts, calm stretches, and long hold-offs
    initial
    begin
        int n;
        int served;
        int left;
        logic calm;
        served = 0;
        left   = 0;
        calm   = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                left = 40;
                calm = ($urandom_range(0, 2) == 0);
            end
            left--;
            if (served != holds_asked)
            begin
                served++;
                out_ready <= 1'b0;
                repeat (HoldCycles) @(negedge clk);
            end
            else if (!quiet && !calm && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 14);
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial
    begin
        logic calm;
        logic kind;
        logic [2:0] code;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        quiet       = 1'b0;
        holds_asked = 0;
        calm        = 1'b0;
        rst_n       = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every key, presses while paused, undecoded keys
        offer_item(ITEM_TICK, BTN_SPARE_C);
        offer_item(ITEM_KEY, BTN_MODE);
        offer_item(ITEM_KEY, BTN_FAN);
        offer_item(ITEM_TICK, BTN_MODE);
        offer_item(ITEM_KEY, BTN_FAN);
        offer_item(ITEM_TICK, BTN_UP);
        offer_item(ITEM_KEY, BTN_POWER);
        offer_item(ITEM_TICK, BTN_FAN);
        offer_item(ITEM_KEY, BTN_DOWN);
        offer_item(ITEM_TICK, BTN_POWER);
        offer_item(ITEM_KEY, BTN_UP);
        offer_item(ITEM_TICK, BTN_DOWN);
        offer_item(ITEM_KEY, BTN_SPARE_A);
        offer_item(ITEM_KEY, BTN_MODE);
        offer_item(ITEM_TICK, BTN_SPARE_B);
        offer_item(ITEM_KEY, BTN_SPARE_C);
        offer_item(ITEM_TICK, BTN_SPARE_A);
        offer_item(ITEM_KEY, BTN_SPARE_B);
        offer_item(ITEM_TICK, BTN_SPARE_C);
        offer_item(ITEM_TICK, BTN_SPARE_C);
        // immediate save, closed window, min above max
        drain_panel();
        set_panel_regs(6'd40, 6'd10, 8'd0, 8'd1);
        offer_item(ITEM_KEY, BTN_UP);
        offer_item(ITEM_TICK, BTN_MODE);
        offer_item(ITEM_KEY, BTN_DOWN);
        offer_item(ITEM_TICK, BTN_MODE);
        offer_item(ITEM_KEY, BTN_POWER);

        // random phases, each under its own register setting
        for (int p = 0; p < PhaseCount; p++)
        begin
            drain_panel();
            case (p)
                0: set_panel_regs(6'd0, 6'd63, 8'd255, 8'd1);
                1: set_panel_regs(6'd63, 6'd0, 8'd0, 8'd0);
                2: set_panel_regs(6'd20, 6'd28, 8'd1, 8'd2);
                3: set_panel_regs(6'd24, 6'd24, 8'd255, 8'd255);
                default: set_panel_regs(6'($urandom), 6'($urandom), 8'($urandom),
                                        8'($urandom_range(0, 12)));
            endcase
            if (p == 1) holds_asked++;
            if (p == PhaseCount - 1) quiet = 1'b1;
            for (int i = 0; i < PhaseItems; i++)
            begin
                if (i % 25 == 0) calm = ($urandom_range(0, 2) == 0);
                if (!quiet && !calm && p != 1 && $urandom_range(0, 7) == 0)
                    pause_input($urandom_range(1, 14));
                // presses and ticks mixed at random so the wake window and saves get used
                kind = ($urandom_range(0, 99) < 45) ? ITEM_KEY : ITEM_TICK;
                code = (kind == ITEM_KEY) ? pick_key() : 3'($urandom_range(0, 7));
                offer_item(kind, code);
            end
        end

        // wrap up
        drain_panel();
        repeat (4) @(negedge clk);
        if (fails == 0)
            $display("climate_panel_settings_controller_unit: match");
        else
            $display("climate_panel_settings_controller_unit: mismatch");
        $finish;
    end

    // run limit
    initial
    begin
        #4_800_000;
        $display("climate_panel_settings_controller_unit: mismatch");
        $finish;
    end

endmodule
